// File: rtl/plcc_pkg.sv
// Shared constants, register codes and helpers for the power-law cell coefficients unit.
// No dependencies; every other file imports this package.
`default_nettype none

package plcc_pkg;

    localparam int Q_FRAC = 16;

    // Face lane: prep, 17 divider steps, 4 power multiplies, conductance multiply, add/sat
    localparam int FACE_DIV_STEPS = 17;
    localparam int FACE_POW_STEPS = 4;
    localparam int FACE_LAT = 1 + FACE_DIV_STEPS + FACE_POW_STEPS + 2;

    // Transient path: two volume multiplies, divider prep, 31 divider steps
    localparam int AP0_DIV_STEPS = 31;
    localparam int AP0_LAT = 3 + AP0_DIV_STEPS;

    // Merge: centre sum and rhs product, then rhs add
    localparam int MERGE_LAT = 2;
    localparam int TOTAL_LAT = AP0_LAT + MERGE_LAT;

    localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;
    localparam logic [30:0] ONE_Q16 = 31'h0001_0000;

    typedef enum logic [2:0] {
        REG_COND_WEST  = 3'd0,
        REG_COND_EAST  = 3'd1,
        REG_COND_SOUTH = 3'd2,
        REG_COND_NORTH = 3'd3,
        REG_TIME_STEP  = 3'd4
    } cfg_reg_t;

    // Clamp an unsigned value to the 31-bit range
    function automatic logic [30:0] sat31(input logic [45:0] v);
        logic [30:0] r;
        r = (v > {15'd0, MAX31}) ? MAX31 : v[30:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/plcc_face_lane.sv
// One face lane: power-law factor (1 - 0.1|F/D|)^5 times D, plus the upwind flow.
// Depends on plcc_pkg.
`default_nettype none

module plcc_face_lane
    import plcc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               ce,
    input  wire logic [30:0]        cond,
    input  wire logic signed [31:0] flow,
    input  wire logic               neg_upwind,
    output logic [30:0]             weight
);

    localparam int DEN_W = 35;
    localparam int NUM_W = DEN_W + Q_FRAC;
    localparam int SIDE_N = 1 + FACE_DIV_STEPS + FACE_POW_STEPS;

    logic [31:0]      mag;
    logic [DEN_W-1:0] ten_d;
    logic             zero_c;
    logic [31:0]      up_c;
    logic [NUM_W-1:0] num_c;

    logic [NUM_W-1:0]          rem_reg [0:FACE_DIV_STEPS];
    logic [FACE_DIV_STEPS-1:0] quo_reg [0:FACE_DIV_STEPS];
    logic                      zero_reg [0:SIDE_N-1];
    logic [31:0]               up_reg [0:SIDE_N-1];
    logic [31:0]               up_last_reg;
    logic [16:0]               pw_reg [0:FACE_POW_STEPS-1];
    logic [16:0]               t_reg [0:FACE_POW_STEPS-2];
    logic [31:0]               diff_reg;
    logic [30:0]               weight_reg;

    logic [33:0] pw_prod [0:FACE_POW_STEPS-1];
    logic [47:0] diff_prod;
    logic [32:0] sum_c;

    // Prep: 10*D is config-only, so the divider stages read it directly
    always_comb begin
        mag = flow[31] ? (~flow + 32'd1) : flow;
        ten_d = ({4'd0, cond} << 3) + ({4'd0, cond} << 1);
        zero_c = ({3'd0, mag} >= ten_d);
        if (neg_upwind) begin
            up_c = flow[31] ? mag : 32'd0;
        end else begin
            up_c = (!flow[31] && (flow != 32'sd0)) ? mag : 32'd0;
        end
        num_c = zero_c ? '0 : {(ten_d - {3'd0, mag}), {Q_FRAC{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg[0] <= num_c;
            quo_reg[0] <= '0;
            zero_reg[0] <= zero_c;
            up_reg[0] <= up_c;
            for (int i = 1; i < SIDE_N; i++) begin
                zero_reg[i] <= zero_reg[i-1];
                up_reg[i] <= up_reg[i-1];
            end
        end
    end

    // Restoring divider, one quotient bit per stage, MSB first
    for (genvar s = 0; s < FACE_DIV_STEPS; s++) begin : g_div
        localparam int K = FACE_DIV_STEPS - 1 - s;
        logic [NUM_W-1:0] shd;
        assign shd = {{(NUM_W-DEN_W){1'b0}}, ten_d} << K;
        always_ff @(posedge aclk) begin
            if (ce) begin
                if (rem_reg[s] >= shd) begin
                    rem_reg[s+1] <= rem_reg[s] - shd;
                    quo_reg[s+1] <= quo_reg[s] | (FACE_DIV_STEPS'(1) << K);
                end else begin
                    rem_reg[s+1] <= rem_reg[s];
                    quo_reg[s+1] <= quo_reg[s];
                end
            end
        end
    end

    // t^5 by four truncating Q16 multiplies
    always_comb begin
        pw_prod[0] = quo_reg[FACE_DIV_STEPS] * quo_reg[FACE_DIV_STEPS];
        for (int i = 1; i < FACE_POW_STEPS; i++) begin
            pw_prod[i] = pw_reg[i-1] * t_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            t_reg[0] <= quo_reg[FACE_DIV_STEPS];
            for (int i = 1; i < FACE_POW_STEPS - 1; i++) begin
                t_reg[i] <= t_reg[i-1];
            end
            for (int i = 0; i < FACE_POW_STEPS; i++) begin
                pw_reg[i] <= pw_prod[i][32:16];
            end
        end
    end

    // Diffusion part D*A, then add upwind part and clamp
    assign diff_prod = cond * pw_reg[FACE_POW_STEPS-1];
    assign sum_c = {1'b0, diff_reg} + {1'b0, up_last_reg};

    always_ff @(posedge aclk) begin
        if (ce) begin
            diff_reg <= zero_reg[SIDE_N-1] ? 32'd0 : diff_prod[47:16];
            // upwind part is registered alongside the diffusion product
            up_last_reg <= up_reg[SIDE_N-1];
            weight_reg <= sat31({13'd0, sum_c});
        end
    end

    assign weight = weight_reg;

endmodule

`default_nettype wire

// File: rtl/plcc_transient.sv
// Transient weight AP0 = rho*dx*dy/dt with saturation at each step.
// Depends on plcc_pkg.
`default_nettype none

module plcc_transient
    import plcc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        ce,
    input  wire logic [30:0] density,
    input  wire logic [30:0] width_x,
    input  wire logic [30:0] width_y,
    input  wire logic [30:0] time_step,
    output logic [30:0]      ap0
);

    localparam int NUM_W = 31 + Q_FRAC;
    localparam int CMP_W = 62;

    logic [61:0] v1_prod;
    logic [61:0] v2_prod;
    logic [30:0] v1_reg;
    logic [30:0] dy_reg;
    logic [30:0] v2_reg;
    logic [30:0] dt;

    logic [NUM_W-1:0]         rem_reg [0:AP0_DIV_STEPS];
    logic [AP0_DIV_STEPS-1:0] quo_reg [0:AP0_DIV_STEPS];
    logic                     ovf_reg [0:AP0_DIV_STEPS];

    // Volume, two saturating Q16 multiplies
    assign v1_prod = density * width_x;
    assign v2_prod = v1_reg * dy_reg;
    assign dt = (time_step == 31'd0) ? 31'd1 : time_step;

    always_ff @(posedge aclk) begin
        if (ce) begin
            v1_reg <= sat31(v1_prod[61:16]);
            dy_reg <= width_y;
            v2_reg <= sat31(v2_prod[61:16]);
            rem_reg[0] <= {v2_reg, {Q_FRAC{1'b0}}};
            quo_reg[0] <= '0;
            // quotient would reach 2^31
            ovf_reg[0] <= ({15'd0, v2_reg} >= {dt, 15'd0});
        end
    end

    // Restoring divider, one quotient bit per stage
    for (genvar s = 0; s < AP0_DIV_STEPS; s++) begin : g_div
        localparam int K = AP0_DIV_STEPS - 1 - s;
        logic [CMP_W-1:0] shd;
        logic [CMP_W-1:0] rem_x;
        logic [CMP_W-1:0] dif;
        assign shd = {{(CMP_W-31){1'b0}}, dt} << K;
        assign rem_x = {{(CMP_W-NUM_W){1'b0}}, rem_reg[s]};
        assign dif = rem_x - shd;
        always_ff @(posedge aclk) begin
            if (ce) begin
                ovf_reg[s+1] <= ovf_reg[s];
                if (rem_x >= shd) begin
                    rem_reg[s+1] <= dif[NUM_W-1:0];
                    quo_reg[s+1] <= quo_reg[s] | (AP0_DIV_STEPS'(1) << K);
                end else begin
                    rem_reg[s+1] <= rem_reg[s];
                    quo_reg[s+1] <= quo_reg[s];
                end
            end
        end
    end

    assign ap0 = ovf_reg[AP0_DIV_STEPS] ? MAX31 : quo_reg[AP0_DIV_STEPS];

endmodule

`default_nettype wire

// File: rtl/plcc_merge.sv
// Merge stage: centre weight from the lane results and AP0, and the right-hand side.
// Depends on plcc_pkg.
`default_nettype none

module plcc_merge
    import plcc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               ce,
    input  wire logic [30:0]        aw,
    input  wire logic [30:0]        ae,
    input  wire logic [30:0]        as_w,
    input  wire logic [30:0]        an,
    input  wire logic [30:0]        ap0,
    input  wire logic signed [31:0] lin_src,
    input  wire logic signed [31:0] con_src,
    input  wire logic signed [31:0] old_val,
    output logic [30:0]             out_w,
    output logic [30:0]             out_e,
    output logic [30:0]             out_s,
    output logic [30:0]             out_n,
    output logic signed [31:0]      centre,
    output logic signed [31:0]      rhs
);

    function automatic logic signed [31:0] sat_s32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic [33:0]        sum_c;
    logic signed [63:0] centre_c;
    logic signed [63:0] rhs_c;

    logic [30:0]        w_reg [0:3];
    logic [30:0]        wo_reg [0:3];
    logic signed [31:0] centre1_reg;
    logic signed [31:0] centre_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] con_reg;
    logic signed [31:0] rhs_reg;

    // Stage 1: neighbor sum plus AP0 minus source slope; AP0 * old value
    assign sum_c = {3'd0, aw} + {3'd0, ae} + {3'd0, as_w} + {3'd0, an} + {3'd0, ap0};
    assign centre_c = $signed({30'd0, sum_c}) - {{32{lin_src[31]}}, lin_src};

    always_ff @(posedge aclk) begin
        if (ce) begin
            w_reg[0] <= aw;
            w_reg[1] <= ae;
            w_reg[2] <= as_w;
            w_reg[3] <= an;
            centre1_reg <= sat_s32(centre_c);
            prod_reg <= $signed({1'b0, ap0}) * old_val;
            con_reg <= con_src;
        end
    end

    // Stage 2: floor shift of the product, add constant source
    assign rhs_c = (prod_reg >>> Q_FRAC) + con_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 4; i++) begin
                wo_reg[i] <= w_reg[i];
            end
            centre_reg <= centre1_reg;
            rhs_reg <= sat_s32(rhs_c);
        end
    end

    assign out_w = wo_reg[0];
    assign out_e = wo_reg[1];
    assign out_s = wo_reg[2];
    assign out_n = wo_reg[3];
    assign centre = centre_reg;
    assign rhs = rhs_reg;

endmodule

`default_nettype wire

// File: rtl/power_law_cell_coefficients_unit.sv
// Throughput: one transaction per cycle while the m_ side is not stalled.
// Pipeline depth is set by the 31-step AP0 divider.
// The whole pipeline advances together and holds while a result waits unaccepted.
// Reset (aresetn low, synchronous) empties the pipeline and sets the config registers to 1.0.
// Depends on plcc_pkg, plcc_face_lane, plcc_transient, plcc_merge.
`default_nettype none

module power_law_cell_coefficients_unit
    import plcc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [30:0]        cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_flow_west,
    input  wire logic signed [31:0] s_flow_east,
    input  wire logic signed [31:0] s_flow_south,
    input  wire logic signed [31:0] s_flow_north,
    input  wire logic [30:0]        s_density,
    input  wire logic [30:0]        s_width_x,
    input  wire logic [30:0]        s_width_y,
    input  wire logic signed [31:0] s_linear_source,
    input  wire logic signed [31:0] s_constant_source,
    input  wire logic signed [31:0] s_old_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [30:0]             m_weight_west,
    output logic [30:0]             m_weight_east,
    output logic [30:0]             m_weight_south,
    output logic [30:0]             m_weight_north,
    output logic signed [31:0]      m_weight_centre,
    output logic signed [31:0]      m_rhs_value
);

    localparam int PAD = AP0_LAT - FACE_LAT;

    logic [30:0] cond_w_reg;
    logic [30:0] cond_e_reg;
    logic [30:0] cond_s_reg;
    logic [30:0] cond_n_reg;
    logic [30:0] dt_reg;

    logic [TOTAL_LAT-1:0] vld_reg;
    logic                 ce;
    logic                 accept;

    logic [30:0] lane_w [0:3];
    logic [30:0] pad_reg [0:3][0:PAD-1];
    logic [30:0] ap0;
    logic signed [31:0] lin_reg [0:AP0_LAT-1];
    logic signed [31:0] con_reg [0:AP0_LAT-1];
    logic signed [31:0] old_reg [0:AP0_LAT-1];

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cond_w_reg <= ONE_Q16;
            cond_e_reg <= ONE_Q16;
            cond_s_reg <= ONE_Q16;
            cond_n_reg <= ONE_Q16;
            dt_reg <= ONE_Q16;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_COND_WEST:  cond_w_reg <= cfg_wdata;
                REG_COND_EAST:  cond_e_reg <= cfg_wdata;
                REG_COND_SOUTH: cond_s_reg <= cfg_wdata;
                REG_COND_NORTH: cond_n_reg <= cfg_wdata;
                REG_TIME_STEP:  dt_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline enable and valid tracking
    assign ce = !m_valid || m_ready;
    assign s_ready = ce;
    assign accept = s_valid && s_ready;
    assign m_valid = vld_reg[TOTAL_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[TOTAL_LAT-2:0], accept};
        end
    end

    // Four face lanes
    plcc_face_lane u_lane_w (
        .aclk(aclk), .ce(ce), .cond(cond_w_reg), .flow(s_flow_west),
        .neg_upwind(1'b0), .weight(lane_w[0])
    );
    plcc_face_lane u_lane_e (
        .aclk(aclk), .ce(ce), .cond(cond_e_reg), .flow(s_flow_east),
        .neg_upwind(1'b1), .weight(lane_w[1])
    );
    plcc_face_lane u_lane_s (
        .aclk(aclk), .ce(ce), .cond(cond_s_reg), .flow(s_flow_south),
        .neg_upwind(1'b0), .weight(lane_w[2])
    );
    plcc_face_lane u_lane_n (
        .aclk(aclk), .ce(ce), .cond(cond_n_reg), .flow(s_flow_north),
        .neg_upwind(1'b1), .weight(lane_w[3])
    );

    plcc_transient u_transient (
        .aclk(aclk), .ce(ce), .density(s_density), .width_x(s_width_x),
        .width_y(s_width_y), .time_step(dt_reg), .ap0(ap0)
    );

    // Align lane results and source terms with AP0
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int l = 0; l < 4; l++) begin
                pad_reg[l][0] <= lane_w[l];
                for (int i = 1; i < PAD; i++) begin
                    pad_reg[l][i] <= pad_reg[l][i-1];
                end
            end
            lin_reg[0] <= s_linear_source;
            con_reg[0] <= s_constant_source;
            old_reg[0] <= s_old_value;
            for (int i = 1; i < AP0_LAT; i++) begin
                lin_reg[i] <= lin_reg[i-1];
                con_reg[i] <= con_reg[i-1];
                old_reg[i] <= old_reg[i-1];
            end
        end
    end

    plcc_merge u_merge (
        .aclk(aclk), .ce(ce),
        .aw(pad_reg[0][PAD-1]), .ae(pad_reg[1][PAD-1]),
        .as_w(pad_reg[2][PAD-1]), .an(pad_reg[3][PAD-1]),
        .ap0(ap0), .lin_src(lin_reg[AP0_LAT-1]), .con_src(con_reg[AP0_LAT-1]),
        .old_val(old_reg[AP0_LAT-1]),
        .out_w(m_weight_west), .out_e(m_weight_east),
        .out_s(m_weight_south), .out_n(m_weight_north),
        .centre(m_weight_centre), .rhs(m_rhs_value)
    );

    // Reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // An empty pipeline with no new transaction cannot produce a result
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg == '0) && !accept |=> !m_valid)
        else $error("result appeared from empty pipeline");

    // A held result freezes the whole valid pipeline
    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(vld_reg))
        else $error("pipeline moved during output stall");

endmodule

`default_nettype wire
